// File: rtl/core/tls_pkg.sv
// shared constants and types for the two-dimensional trilateration solver
// no dependencies; imported by tls_div_pipe, trilateration_2d_solver and the testbench
package tls_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TOL_WIDTH = 8;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 8'd3;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_SAME_X = 2'd1,
        STAT_DEGEN  = 2'd2
    } status_t;

endpackage

// File: rtl/core/tls_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, rounded and saturated
// depends on tls_pkg for the default coordinate width
module tls_div_pipe
#(
    parameter int COORD_WIDTH = tls_pkg::COORD_WIDTH_DEF,
    parameter int NUM_WIDTH   = 3 * tls_pkg::COORD_WIDTH_DEF + 4,
    parameter int DEN_WIDTH   = 2 * tls_pkg::COORD_WIDTH_DEF + 5
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [NUM_WIDTH-1:0]          num,
    input  logic [DEN_WIDTH-1:0]          den,
    input  logic                          neg,
    output logic signed [COORD_WIDTH-1:0] quo
);
    import tls_pkg::*;

    localparam int QB = COORD_WIDTH + 1;
    localparam int RW = DEN_WIDTH + 1;

    localparam logic [QB:0] MAG_MAX = {3'b000, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [QB:0] MAG_MIN = {3'b001, {(COORD_WIDTH-1){1'b0}}};

    logic [RW-1:0]        rem_reg  [0:QB];
    logic [QB-1:0]        low_reg  [0:QB];
    logic [QB-1:0]        bits_reg [0:QB];
    logic [DEN_WIDTH-1:0] den_reg  [0:QB];
    logic                 neg_reg  [0:QB];
    logic                 ovf_reg  [0:QB];

    logic [RW-1:0] rem_next;
    logic          ovf_next;

    logic                          round_up;
    logic [QB:0]                   mag_rnd;
    logic signed [COORD_WIDTH-1:0] quo_next;
    logic signed [COORD_WIDTH-1:0] quo_reg;

    // quotient of 2^QB or more only ever saturates
    always_comb
    begin
        ovf_next = (num[NUM_WIDTH-1:QB] >= den);
        rem_next = RW'(num[NUM_WIDTH-1:QB]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next;
            low_reg[0]  <= num[QB-1:0];
            bits_reg[0] <= '0;
            den_reg[0]  <= den;
            neg_reg[0]  <= neg;
            ovf_reg[0]  <= ovf_next;
        end
    end

    for (genvar i = 1; i <= QB; i++)
    begin : g_stage
        logic [RW-1:0] trial;
        logic          ge;
        logic [RW-1:0] rem_stage_next;

        always_comb
        begin
            trial          = {rem_reg[i-1][RW-2:0], low_reg[i-1][QB-1]};
            ge             = (trial >= RW'(den_reg[i-1]));
            rem_stage_next = ge ? (trial - RW'(den_reg[i-1])) : trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_stage_next;
                low_reg[i]  <= {low_reg[i-1][QB-2:0], 1'b0};
                bits_reg[i] <= {bits_reg[i-1][QB-2:0], ge};
                den_reg[i]  <= den_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
                ovf_reg[i]  <= ovf_reg[i-1];
            end
        end
    end

    // ties round away from zero on the magnitude
    always_comb
    begin
        round_up = ({rem_reg[QB], 1'b0} >= (RW+1)'(den_reg[QB]));
        mag_rnd  = (QB+1)'(bits_reg[QB]) + (QB+1)'(round_up);
        if (neg_reg[QB])
        begin
            if (ovf_reg[QB] || (mag_rnd >= MAG_MIN))
                quo_next = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            else
                quo_next = -$signed(mag_rnd[COORD_WIDTH-1:0]);
        end
        else
        begin
            if (ovf_reg[QB] || (mag_rnd > MAG_MAX))
                quo_next = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            else
                quo_next = $signed(mag_rnd[COORD_WIDTH-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

// File: rtl/core/trilateration_2d_solver.sv
// path from input transfer to result: stages 1 to 5, the divider stages, then the output register
// throughput: one measurement set per cycle; the whole pipeline halts while a result waits
// the depth is set by the two restoring dividers, one quotient bit per stage
// reset clears every valid bit and sets the tolerance register tol_reg to 3
// top level of the trilateration solver; depends on tls_pkg and tls_div_pipe
module trilateration_2d_solver
#(
    parameter int COORD_WIDTH = tls_pkg::COORD_WIDTH_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [tls_pkg::TOL_WIDTH-1:0]           cfg_wr_data,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // anchor_a_x, anchor_a_y, range_a, anchor_b_x, anchor_b_y, range_b,
    // anchor_c_x, anchor_c_y, range_c, zero pad
    input  logic [((9*COORD_WIDTH-3+7)/8)*8-1:0]    s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // target_x, target_y, zero pad
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]      m_tdata,
    // solve_status
    output logic [1:0]                              m_tuser
);
    import tls_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int RNG_W   = W - 1;
    localparam int AW      = W + 2;
    localparam int SQW     = 2 * W;
    localparam int RSQW    = 2 * W - 2;
    localparam int CW      = 2 * W + 1;
    localparam int PW      = 2 * W + 4;
    localparam int DW      = 2 * W + 5;
    localparam int LW      = W + 1;
    localparam int HPW     = 2 * W + 2;
    localparam int NXW     = 3 * W + 4;
    localparam int OFF_B   = 3 * W - 1;
    localparam int OFF_C   = 2 * (3 * W - 1);
    localparam int OUT_TW  = ((2 * W + 7) / 8) * 8;
    localparam int DIV_LAT = W + 3;

    logic pipe_en;

    logic [TOL_WIDTH-1:0] tol_reg;

    // input unpacking
    logic signed [W-1:0] ax, ay, bx, by, cx, cy;
    logic [RNG_W-1:0]    ra, rb, rc;

    // stage 1: pivot choice
    logic signed [W:0] d_ab, d_ac;
    logic [W:0]        m_ab, m_ac;
    logic              close_ab, close_ac;

    logic signed [W-1:0] px_next, py_next, q1x_next, q1y_next, q2x_next, q2y_next;
    logic [RNG_W-1:0]    pr_next, q1r_next, q2r_next;
    logic                same_x_next;

    logic                s1_valid_reg;
    logic signed [W-1:0] px_reg, py_reg, q1x_reg, q1y_reg, q2x_reg, q2y_reg;
    logic [RNG_W-1:0]    pr_reg, q1r_reg, q2r_reg;
    logic                s1_same_x_reg;

    // stage 2: line coefficients and squares
    logic signed [W:0]    dx1, dy1, dx2, dy2;
    logic signed [AW-1:0] a1_next, b1_next, a2_next, b2_next;
    logic signed [SQW-1:0] sq_px_next, sq_py_next, sq_q1x_next, sq_q1y_next;
    logic signed [SQW-1:0] sq_q2x_next, sq_q2y_next;
    logic [RSQW-1:0]      sq_pr_next, sq_q1r_next, sq_q2r_next;

    logic                  s2_valid_reg;
    logic                  s2_same_x_reg;
    logic signed [AW-1:0]  s2_a1_reg, s2_b1_reg, s2_a2_reg, s2_b2_reg;
    logic signed [SQW-1:0] sq_px_reg, sq_py_reg, sq_q1x_reg, sq_q1y_reg;
    logic signed [SQW-1:0] sq_q2x_reg, sq_q2y_reg;
    logic [RSQW-1:0]       sq_pr_reg, sq_q1r_reg, sq_q2r_reg;

    // stage 3: right-hand sides and determinant products
    logic signed [CW-1:0] c1_next, c2_next;
    logic signed [PW-1:0] pa_next, pb_next;

    logic                 s3_valid_reg;
    logic                 s3_same_x_reg;
    logic signed [AW-1:0] s3_a1_reg, s3_b1_reg, s3_a2_reg, s3_b2_reg;
    logic signed [CW-1:0] c1_reg, c2_reg;
    logic signed [PW-1:0] pa_reg, pb_reg;

    // stage 4: determinant and numerator partial products
    logic signed [DW-1:0]  det_next;
    logic signed [LW:0]    c1_lo, c2_lo;
    logic signed [W-1:0]   c1_hi, c2_hi;
    logic signed [PW-1:0]  xl1_next, xl2_next, yl1_next, yl2_next;
    logic signed [HPW-1:0] xh1_next, xh2_next, yh1_next, yh2_next;

    logic                  s4_valid_reg;
    logic                  s4_same_x_reg;
    logic signed [DW-1:0]  det_reg;
    logic signed [PW-1:0]  xl1_reg, xl2_reg, yl1_reg, yl2_reg;
    logic signed [HPW-1:0] xh1_reg, xh2_reg, yh1_reg, yh2_reg;

    // stage 5: numerators, magnitudes, signs and status
    logic signed [NXW-1:0] nx, ny;
    logic [NXW-1:0]        nx_mag_next, ny_mag_next;
    logic [DW-1:0]         det_mag_next;
    logic                  negx_next, negy_next;
    status_t               stat_next;

    logic                  s5_valid_reg;
    logic [NXW-1:0]        nx_mag_reg, ny_mag_reg;
    logic [DW-1:0]         det_mag_reg;
    logic                  negx_reg, negy_reg;
    status_t               s5_stat_reg;

    // divider stages
    logic signed [W-1:0] quo_x, quo_y;
    logic                div_valid_reg [0:DIV_LAT-1];
    status_t             div_stat_reg  [0:DIV_LAT-1];

    // output register
    logic                out_valid_reg;
    logic [OUT_TW-1:0]   out_data_reg;
    status_t             out_stat_reg;
    logic [OUT_TW-1:0]   out_data_next;

    assign pipe_en  = !out_valid_reg || m_tready;
    assign s_tready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_wr_en)
            tol_reg <= cfg_wr_data;
    end

    always_comb
    begin
        ax = $signed(s_tdata[W-1:0]);
        ay = $signed(s_tdata[2*W-1:W]);
        ra = s_tdata[3*W-2:2*W];
        bx = $signed(s_tdata[OFF_B+W-1:OFF_B]);
        by = $signed(s_tdata[OFF_B+2*W-1:OFF_B+W]);
        rb = s_tdata[OFF_B+3*W-2:OFF_B+2*W];
        cx = $signed(s_tdata[OFF_C+W-1:OFF_C]);
        cy = $signed(s_tdata[OFF_C+2*W-1:OFF_C+W]);
        rc = s_tdata[OFF_C+3*W-2:OFF_C+2*W];
    end

    // stage 1
    always_comb
    begin
        d_ab     = (W+1)'(ax) - (W+1)'(bx);
        d_ac     = (W+1)'(ax) - (W+1)'(cx);
        m_ab     = d_ab[W] ? $unsigned(-d_ab) : $unsigned(d_ab);
        m_ac     = d_ac[W] ? $unsigned(-d_ac) : $unsigned(d_ac);
        close_ab = (m_ab < (W+1)'(tol_reg));
        close_ac = (m_ac < (W+1)'(tol_reg));

        same_x_next = close_ab && close_ac;
        q1x_next    = ax;
        q1y_next    = ay;
        q1r_next    = ra;
        if (close_ab)
        begin
            px_next  = cx;  py_next  = cy;  pr_next  = rc;
            q2x_next = bx;  q2y_next = by;  q2r_next = rb;
        end
        else if (close_ac)
        begin
            px_next  = bx;  py_next  = by;  pr_next  = rb;
            q2x_next = cx;  q2y_next = cy;  q2r_next = rc;
        end
        else
        begin
            px_next  = ax;  py_next  = ay;  pr_next  = ra;
            q1x_next = bx;  q1y_next = by;  q1r_next = rb;
            q2x_next = cx;  q2y_next = cy;  q2r_next = rc;
        end
    end

    // stage 2
    always_comb
    begin
        dx1     = (W+1)'(px_reg) - (W+1)'(q1x_reg);
        dy1     = (W+1)'(py_reg) - (W+1)'(q1y_reg);
        dx2     = (W+1)'(px_reg) - (W+1)'(q2x_reg);
        dy2     = (W+1)'(py_reg) - (W+1)'(q2y_reg);
        a1_next = {dx1, 1'b0};
        b1_next = {dy1, 1'b0};
        a2_next = {dx2, 1'b0};
        b2_next = {dy2, 1'b0};

        sq_px_next  = px_reg * px_reg;
        sq_py_next  = py_reg * py_reg;
        sq_q1x_next = q1x_reg * q1x_reg;
        sq_q1y_next = q1y_reg * q1y_reg;
        sq_q2x_next = q2x_reg * q2x_reg;
        sq_q2y_next = q2y_reg * q2y_reg;
        sq_pr_next  = pr_reg * pr_reg;
        sq_q1r_next = q1r_reg * q1r_reg;
        sq_q2r_next = q2r_reg * q2r_reg;
    end

    // stage 3
    always_comb
    begin
        c1_next = CW'(sq_px_reg) - CW'(sq_q1x_reg) + CW'(sq_py_reg) - CW'(sq_q1y_reg)
                + CW'(sq_q1r_reg) - CW'(sq_pr_reg);
        c2_next = CW'(sq_px_reg) - CW'(sq_q2x_reg) + CW'(sq_py_reg) - CW'(sq_q2y_reg)
                + CW'(sq_q2r_reg) - CW'(sq_pr_reg);
        pa_next = s2_a1_reg * s2_b2_reg;
        pb_next = s2_a2_reg * s2_b1_reg;
    end

    // stage 4: each right-hand side split into a low and a high part
    always_comb
    begin
        det_next = DW'(pa_reg) - DW'(pb_reg);
        c1_lo    = $signed({1'b0, c1_reg[LW-1:0]});
        c2_lo    = $signed({1'b0, c2_reg[LW-1:0]});
        c1_hi    = c1_reg[CW-1:LW];
        c2_hi    = c2_reg[CW-1:LW];
        xl1_next = c1_lo * s3_b2_reg;
        xh1_next = c1_hi * s3_b2_reg;
        xl2_next = c2_lo * s3_b1_reg;
        xh2_next = c2_hi * s3_b1_reg;
        yl1_next = c2_lo * s3_a1_reg;
        yh1_next = c2_hi * s3_a1_reg;
        yl2_next = c1_lo * s3_a2_reg;
        yh2_next = c1_hi * s3_a2_reg;
    end

    // stage 5
    always_comb
    begin
        nx = (NXW'(xh1_reg) <<< LW) + NXW'(xl1_reg) - (NXW'(xh2_reg) <<< LW) - NXW'(xl2_reg);
        ny = (NXW'(yh1_reg) <<< LW) + NXW'(yl1_reg) - (NXW'(yh2_reg) <<< LW) - NXW'(yl2_reg);
        nx_mag_next  = nx[NXW-1] ? $unsigned(-nx) : $unsigned(nx);
        ny_mag_next  = ny[NXW-1] ? $unsigned(-ny) : $unsigned(ny);
        det_mag_next = det_reg[DW-1] ? $unsigned(-det_reg) : $unsigned(det_reg);
        negx_next    = nx[NXW-1] ^ det_reg[DW-1];
        negy_next    = ny[NXW-1] ^ det_reg[DW-1];
        if (s4_same_x_reg)
            stat_next = STAT_SAME_X;
        else if (det_reg == '0)
            stat_next = STAT_DEGEN;
        else
            stat_next = STAT_OK;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            px_reg        <= px_next;
            py_reg        <= py_next;
            pr_reg        <= pr_next;
            q1x_reg       <= q1x_next;
            q1y_reg       <= q1y_next;
            q1r_reg       <= q1r_next;
            q2x_reg       <= q2x_next;
            q2y_reg       <= q2y_next;
            q2r_reg       <= q2r_next;
            s1_same_x_reg <= same_x_next;

            s2_same_x_reg <= s1_same_x_reg;
            s2_a1_reg     <= a1_next;
            s2_b1_reg     <= b1_next;
            s2_a2_reg     <= a2_next;
            s2_b2_reg     <= b2_next;
            sq_px_reg     <= sq_px_next;
            sq_py_reg     <= sq_py_next;
            sq_q1x_reg    <= sq_q1x_next;
            sq_q1y_reg    <= sq_q1y_next;
            sq_q2x_reg    <= sq_q2x_next;
            sq_q2y_reg    <= sq_q2y_next;
            sq_pr_reg     <= sq_pr_next;
            sq_q1r_reg    <= sq_q1r_next;
            sq_q2r_reg    <= sq_q2r_next;

            s3_same_x_reg <= s2_same_x_reg;
            s3_a1_reg     <= s2_a1_reg;
            s3_b1_reg     <= s2_b1_reg;
            s3_a2_reg     <= s2_a2_reg;
            s3_b2_reg     <= s2_b2_reg;
            c1_reg        <= c1_next;
            c2_reg        <= c2_next;
            pa_reg        <= pa_next;
            pb_reg        <= pb_next;

            s4_same_x_reg <= s3_same_x_reg;
            det_reg       <= det_next;
            xl1_reg       <= xl1_next;
            xl2_reg       <= xl2_next;
            xh1_reg       <= xh1_next;
            xh2_reg       <= xh2_next;
            yl1_reg       <= yl1_next;
            yl2_reg       <= yl2_next;
            yh1_reg       <= yh1_next;
            yh2_reg       <= yh2_next;

            nx_mag_reg    <= nx_mag_next;
            ny_mag_reg    <= ny_mag_next;
            det_mag_reg   <= det_mag_next;
            negx_reg      <= negx_next;
            negy_reg      <= negy_next;
            s5_stat_reg   <= stat_next;

            div_stat_reg[0] <= s5_stat_reg;
            for (int i = 1; i < DIV_LAT; i++)
                div_stat_reg[i] <= div_stat_reg[i-1];

            out_data_reg <= out_data_next;
            out_stat_reg <= div_stat_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
                div_valid_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg     <= s_tvalid;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            s5_valid_reg     <= s4_valid_reg;
            div_valid_reg[0] <= s5_valid_reg;
            for (int i = 1; i < DIV_LAT; i++)
                div_valid_reg[i] <= div_valid_reg[i-1];
            out_valid_reg    <= div_valid_reg[DIV_LAT-1];
        end
    end

    tls_div_pipe #(
        .COORD_WIDTH (W),
        .NUM_WIDTH   (NXW),
        .DEN_WIDTH   (DW)
    ) u_div_x (
        .clk (clk),
        .en  (pipe_en),
        .num (nx_mag_reg),
        .den (det_mag_reg),
        .neg (negx_reg),
        .quo (quo_x)
    );

    tls_div_pipe #(
        .COORD_WIDTH (W),
        .NUM_WIDTH   (NXW),
        .DEN_WIDTH   (DW)
    ) u_div_y (
        .clk (clk),
        .en  (pipe_en),
        .num (ny_mag_reg),
        .den (det_mag_reg),
        .neg (negy_reg),
        .quo (quo_y)
    );

    // position is forced to zero unless the solve succeeded
    always_comb
    begin
        if (div_stat_reg[DIV_LAT-1] == STAT_OK)
            out_data_next = OUT_TW'({quo_y, quo_x});
        else
            out_data_next = '0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_stat_reg;

    a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("position not cleared on failed solve");

    a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(s1_valid_reg) && $stable(s5_valid_reg))
        else $error("pipeline valid moved during stall");

    a_same_x_travels: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_same_x_reg && pipe_en |=> s2_valid_reg && s2_same_x_reg)
        else $error("shared-x flag lost between stages");

endmodule

// File: sim/trilateration_2d_solver_tb.sv
// self-checking testbench for the two-dimensional trilateration solver
// predicts each target position and status with exact 256-bit arithmetic;
// depends on tls_pkg and the solver RTL
module trilateration_2d_solver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tls_pkg::*;

    localparam int CW = 32;
    localparam int LAT = CW + 9;

    typedef struct {
        logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
        logic [CW-2:0]        ra, rb, rc;
    } anchors_t;

    typedef struct {
        logic signed [CW-1:0] tx, ty;
        status_t              st;
    } fix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [TOL_WIDTH-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [287:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0] m_tuser;

    anchors_t pending_q[$];
    fix_t     fix_q[$];
    anchors_t in_flight;
    logic [TOL_WIDTH-1:0] tol_copy = TOL_RESET;
    int errors = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_cnt = 0;

    trilateration_2d_solver u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic x_close(logic signed [255:0] u, logic signed [255:0] v,
                                     logic [TOL_WIDTH-1:0] tol);
        logic signed [255:0] d;
        d = u - v;
        if (d < 0)
            d = -d;
        return d < $signed({248'd0, tol});
    endfunction

    // rounded quotient, ties away from zero, saturated to the coordinate range
    function automatic logic signed [CW-1:0] round_div(logic signed [255:0] n,
                                                        logic signed [255:0] d);
        logic neg;
        logic [255:0] an, ad, q, r;
        neg = n[255] ^ d[255];
        an = n[255] ? -n : n;
        ad = d[255] ? -d : d;
        q = an / ad;
        r = an % ad;
        if ((r << 1) >= ad)
            q = q + 1;
        if (neg)
            return (q >= 256'h8000_0000) ? 32'sh8000_0000 : -$signed(q[CW-1:0]);
        return (q > 256'h7fff_ffff) ? 32'sh7fff_ffff : $signed(q[CW-1:0]);
    endfunction

    function automatic fix_t solve_fix(anchors_t it, logic [TOL_WIDTH-1:0] tol);
        logic signed [255:0] px[3], py[3], pr[3], la[3], lb[3], lc[3];
        logic signed [255:0] det, nx, ny;
        int ord[3];
        int p, q;
        fix_t f;
        px[0] = it.ax; py[0] = it.ay; pr[0] = $signed({225'd0, it.ra});
        px[1] = it.bx; py[1] = it.by; pr[1] = $signed({225'd0, it.rb});
        px[2] = it.cx; py[2] = it.cy; pr[2] = $signed({225'd0, it.rc});
        f.tx = '0;
        f.ty = '0;
        f.st = STAT_OK;
        if (x_close(px[0], px[1], tol))
        begin
            if (x_close(px[0], px[2], tol))
            begin
                f.st = STAT_SAME_X;
                return f;
            end
            ord = '{2, 0, 1};
        end
        else if (x_close(px[0], px[2], tol))
            ord = '{1, 0, 2};
        else
            ord = '{0, 1, 2};
        for (int k = 1; k < 3; k++)
        begin
            p = ord[0];
            q = ord[k];
            la[k] = 2 * (px[p] - px[q]);
            lb[k] = 2 * (py[p] - py[q]);
            lc[k] = px[p]*px[p] - px[q]*px[q] + py[p]*py[p] - py[q]*py[q]
                    + pr[q]*pr[q] - pr[p]*pr[p];
        end
        det = la[1]*lb[2] - la[2]*lb[1];
        if (det == 0)
        begin
            f.st = STAT_DEGEN;
            return f;
        end
        nx = lc[1]*lb[2] - lc[2]*lb[1];
        ny = la[1]*lc[2] - la[2]*lc[1];
        f.tx = round_div(nx, det);
        f.ty = round_div(ny, det);
        return f;
    endfunction

    function automatic logic [CW-2:0] dist_to(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                             real tx, real ty);
        real dx, dy, r;
        dx = real'(x) - tx;
        dy = real'(y) - ty;
        r = $sqrt(dx*dx + dy*dy) + 0.5;
        if (r > 2147483647.0)
            r = 2147483647.0;
        return (CW-1)'($rtoi(r));
    endfunction

    function automatic logic signed [CW-1:0] edge_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return 32'sh0000_0001;
            4: return -32'sd1;
            default: return $signed($urandom_range(0, 511)) - 256;
        endcase
    endfunction

    function automatic anchors_t random_set(logic [TOL_WIDTH-1:0] tol);
        anchors_t it;
        int kind, span, jit;
        real tx, ty;
        kind = $urandom_range(0, 99);
        span = ($urandom_range(0, 3) == 0) ? (1 << 24) : (1 << 16);
        it.ax = $signed($urandom_range(0, 2*span)) - span;
        it.ay = $signed($urandom_range(0, 2*span)) - span;
        it.bx = $signed($urandom_range(0, 2*span)) - span;
        it.by = $signed($urandom_range(0, 2*span)) - span;
        it.cx = $signed($urandom_range(0, 2*span)) - span;
        it.cy = $signed($urandom_range(0, 2*span)) - span;
        jit = int'(tol) + 2;
        // push some x values inside or just around the tolerance band, or place c midway between a and b
        if (kind >= 55 && kind < 65)
            it.bx = it.ax + $signed($urandom_range(0, 2*jit)) - jit;
        else if (kind >= 65 && kind < 72)
            it.cx = it.ax + $signed($urandom_range(0, 2*jit)) - jit;
        else if (kind >= 72 && kind < 77)
        begin
            it.bx = it.ax + $signed($urandom_range(0, 2*jit)) - jit;
            it.cx = it.ax + $signed($urandom_range(0, 2*jit)) - jit;
        end
        else if (kind >= 77 && kind < 80)
        begin
            it.bx = it.ax + 2*(it.cx - it.ax);
            it.by = it.ay + 2*(it.cy - it.ay);
        end
        tx = real'($signed($urandom_range(0, 2*span)) - span);
        ty = real'($signed($urandom_range(0, 2*span)) - span);
        it.ra = dist_to(it.ax, it.ay, tx, ty);
        it.rb = dist_to(it.bx, it.by, tx, ty);
        it.rc = dist_to(it.cx, it.cy, tx, ty);
        if (kind >= 80 && kind < 92)
        begin
            it.ax = $urandom; it.ay = $urandom; it.bx = $urandom;
            it.by = $urandom; it.cx = $urandom; it.cy = $urandom;
            it.ra = (CW-1)'($urandom);
            it.rb = (CW-1)'($urandom);
            it.rc = (CW-1)'($urandom);
        end
        else if (kind >= 92)
        begin
            it.ax = edge_val(); it.ay = edge_val(); it.bx = edge_val();
            it.by = edge_val(); it.cx = edge_val(); it.cy = edge_val();
            it.ra = ($urandom_range(0, 1) == 1) ? '1 : (CW-1)'($urandom);
            it.rb = ($urandom_range(0, 1) == 1) ? '0 : (CW-1)'($urandom);
            it.rc = (CW-1)'($urandom);
        end
        return it;
    endfunction

    function automatic anchors_t mk(int ax, int ay, int ra, int bx, int by, int rb,
                                    int cx, int cy, int rc);
        anchors_t it;
        it.ax = ax; it.ay = ay; it.ra = (CW-1)'(ra);
        it.bx = bx; it.by = by; it.rb = (CW-1)'(rb);
        it.cx = cx; it.cy = cy; it.rc = (CW-1)'(rc);
        return it;
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        anchors_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                fix_q.push_back(solve_fix(in_flight, tol_copy));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    nxt = pending_q.pop_front();
                    in_flight = nxt;
                    s_tdata <= {3'b000, nxt.rc, nxt.cy, nxt.cx, nxt.rb, nxt.by, nxt.bx,
                                nxt.ra, nxt.ay, nxt.ax};
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left = burst_left - 1;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches each time stall_cnt wraps
    always @(posedge clk)
    begin
        fix_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (fix_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transfer: x=%0d y=%0d status=%0d",
                                 $signed(m_tdata[31:0]), $signed(m_tdata[63:32]), m_tuser);
                end
                else
                begin
                    want = fix_q.pop_front();
                    if (m_tdata[31:0] !== want.tx || m_tdata[63:32] !== want.ty
                        || m_tuser !== want.st)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp x=%0d y=%0d status=%0d,",
                                      " got x=%0d y=%0d status=%0d"},
                                     want.tx, want.ty, want.st, $signed(m_tdata[31:0]),
                                     $signed(m_tdata[63:32]), m_tuser);
                    end
                end
            end
            stall_cnt++;
            if (stall_cnt == 64)
            begin
                stall_cnt = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= (stall_cnt[3:0] < 4'd10);
            endcase
        end
    end

    task automatic drain();
        @(posedge clk);
        while (pending_q.size() != 0 || fix_q.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (LAT + 10) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [TOL_WIDTH-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        tol_copy = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [TOL_WIDTH-1:0] tols[5];
        tols = '{8'd0, 8'd255, 8'd17, 8'd1, 8'd3};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed cases at the reset tolerance
        pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(0, 0, 1280, 2560, 0, 1280, 0, 2560, 1810));
        pending_q.push_back(mk(0, 0, 100, 1, 500, 100, 2560, 0, 100));
        pending_q.push_back(mk(0, 0, 100, 2560, 0, 100, 2, 700, 100));
        pending_q.push_back(mk(0, 0, 100, 2, 900, 100, -2, 40, 100));
        pending_q.push_back(mk(0, 0, 5, 256, 256, 7, 512, 512, 9));
        pending_q.push_back(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_q.push_back(mk(0, 0, 0, 3, 0, 0, 0, 3, 0));
        pending_q.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                               32'h80000000, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
        pending_q.push_back(mk(32'h80000000, 0, 0, 32'h7fffffff, 0, 32'h7fffffff,
                               0, 1, 32'h7fffffff));
        pending_q.push_back(mk(0, 0, 32'h7fffffff, 10, 0, 0, 0, 10, 0));
        pending_q.push_back(mk(0, 0, 0, 10, 0, 32'h7fffffff, 0, 10, 0));
        pending_q.push_back(mk(-512, 300, 777, 640, -128, 900, 100, 1000, 333));
        pending_q.push_back(mk(0, 0, 1, 1, 1, 0, 7, 1, 0));
        for (int i = 0; i < 120; i++)
            pending_q.push_back(random_set(tol_copy));
        drain();

        foreach (tols[t])
        begin
            write_tolerance(tols[t]);
            pending_q.push_back(mk(0, 0, 0, tols[t], 5, 0, 0, 9, 0));
            pending_q.push_back(mk(0, 0, 0, int'(tols[t]) - 1, 5, 0, 4, 9, 0));
            for (int i = 0; i < 120; i++)
                pending_q.push_back(random_set(tol_copy));
            drain();
        end

        if (errors == 0 && fix_q.size() == 0)
            $display("** trilateration_2d_solver: PASSED **");
        else
            $display("** trilateration_2d_solver: FAILED **");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("** trilateration_2d_solver: FAILED **");
        $finish;
    end

endmodule
